// ===== rtl/core/mexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation pipeline.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int unsigned BASE_W  = 30;
   localparam int unsigned EXPO_W  = 32;
   localparam int unsigned RES_W   = 30;
   // scanned exponent bits, 1 to 64
   localparam int unsigned EXP_BITS = 32;

   // latency of one modular multiplier
   localparam int unsigned MUL_LAT = 4;

   localparam logic [RES_W-1:0] PRIME = 30'd998244353;
   localparam logic [RES_W-1:0] ONE   = 30'd1;

   // Barrett reciprocal, floor(2^60 / PRIME), fits in 31 bits
   localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd998244353;
   localparam logic [30:0] MU      = MU_FULL[30:0];

endpackage : mexp_pkg
`default_nettype wire

// ===== rtl/core/mexp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_req_if / mexp_rsp_if
// Valid/ready channels for requests (base, exponent) and responses (power).
// ----------------------------------------------------------------------------
interface mexp_req_if;
   logic        valid;
   logic        ready;
   logic [29:0] base;
   logic [31:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface : mexp_req_if

interface mexp_rsp_if;
   logic        valid;
   logic        ready;
   logic [29:0] power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface : mexp_rsp_if
`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulmod
// Pipelined a*b mod PRIME, Barrett reduction, four register stages.
// ----------------------------------------------------------------------------
module mexp_mulmod
   import mexp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [RES_W-1:0] a,
   input  wire logic [RES_W-1:0] b,
   output logic      [RES_W-1:0] r
);

   logic [59:0] prod_ff, prod_in;
   logic [61:0] t_ff, t_in;
   logic [31:0] zlo_ff;
   logic [31:0] rem_ff, rem_in;
   logic [RES_W-1:0] r_ff, r_in;
   logic [30:0] q;
   logic [61:0] qp;
   logic [31:0] two_p;

   always_comb begin
      prod_in = 60'(a) * 60'(b);
      t_in    = 62'(prod_ff[59:29]) * 62'(MU);
      q       = t_ff[61:31];
      qp      = 62'(q) * 62'(PRIME);
      // true remainder is below 3*PRIME, so 32 bits suffice
      rem_in  = zlo_ff - qp[31:0];
      two_p   = {1'b0, PRIME, 1'b0};
      if (rem_ff >= two_p) begin
         r_in = RES_W'(rem_ff - two_p);
      end else if (rem_ff >= 32'(PRIME)) begin
         r_in = RES_W'(rem_ff - 32'(PRIME));
      end else begin
         r_in = rem_ff[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         t_ff    <= t_in;
         zlo_ff  <= prod_ff[31:0];
         rem_ff  <= rem_in;
         r_ff    <= r_in;
      end
   end

   assign r = r_ff;

endmodule : mexp_mulmod
`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// power = base ^ exponent mod 998244353, right-to-left square-and-multiply,
// fully unrolled: one multiplier pair per exponent bit.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   base[29:0], exponent[31:0]
//  rsp      out  power[29:0]
//
//  One register stage reduces the base, then each exponent bit uses two
//  four-stage modular multipliers. A new item is taken every cycle while
//  the response is not stalled. Reset clears the valid bits only.
//  A stalled response freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module modular_exponentiation
   import mexp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mexp_req_if.sink   req_if,
   mexp_rsp_if.source rsp_if
);

   logic enable;
   logic [RES_W-1:0]  acc [EXP_BITS+1];
   logic [RES_W-1:0]  sq  [EXP_BITS+1];
   logic [EXPO_W-1:0] ex  [EXP_BITS+1];
   logic              vld [EXP_BITS+1];

   logic [RES_W-1:0]  base_ff, base_in;
   logic [EXPO_W-1:0] expo_ff;
   logic              valid_ff;

   assign enable = !vld[EXP_BITS] || rsp_if.ready;
   assign req_if.ready = enable;

   always_comb begin
      base_in = (req_if.base >= PRIME) ? RES_W'(req_if.base - PRIME) : req_if.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req_if.valid;
      end
      if (enable) begin
         base_ff <= base_in;
         expo_ff <= req_if.exponent;
      end
   end

   assign acc[0] = ONE;
   assign sq[0]  = base_ff;
   assign ex[0]  = expo_ff;
   assign vld[0] = valid_ff;

   for (genvar i = 0; i < EXP_BITS; i++) begin : g_bit
      logic              bit_set;
      logic [RES_W-1:0]  mult;
      logic [EXPO_W-1:0] ex_ff [MUL_LAT];
      logic              v_ff  [MUL_LAT];

      if (i < EXPO_W) begin : g_in
         assign bit_set = ex[i][i];
      end else begin : g_pad
         assign bit_set = 1'b0;
      end

      assign mult = bit_set ? sq[i] : ONE;

      mexp_mulmod u_acc (
         .clock  (clock),
         .enable (enable),
         .a      (acc[i]),
         .b      (mult),
         .r      (acc[i+1])
      );

      mexp_mulmod u_sq (
         .clock  (clock),
         .enable (enable),
         .a      (sq[i]),
         .b      (sq[i]),
         .r      (sq[i+1])
      );

      always_ff @(posedge clock) begin
         for (int k = 0; k < MUL_LAT; k++) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (enable) begin
               v_ff[k] <= (k == 0) ? vld[i] : v_ff[(k == 0) ? 0 : k-1];
            end
            if (enable) begin
               ex_ff[k] <= (k == 0) ? ex[i] : ex_ff[(k == 0) ? 0 : k-1];
            end
         end
      end

      assign ex[i+1]  = ex_ff[MUL_LAT-1];
      assign vld[i+1] = v_ff[MUL_LAT-1];
   end

   assign rsp_if.valid = vld[EXP_BITS];
   assign rsp_if.power = acc[EXP_BITS];

endmodule : modular_exponentiation
`default_nettype wire

// ===== tb/sv/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Watches the request and response channels, computes the expected power for
// each accepted request and compares it with each accepted response in order.
// ----------------------------------------------------------------------------
module mexp_checker
   import mexp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mexp_req_if       req_if,
   mexp_rsp_if       rsp_if,
   output int        error_count,
   output int        pending_count
);

   logic [RES_W-1:0] power_queue[$];

   function automatic logic [RES_W-1:0] mod_mul(logic [RES_W-1:0] x, logic [RES_W-1:0] y);
      logic [63:0] prod;
      prod = 64'(x) * 64'(y);
      return RES_W'(prod % 64'(PRIME));
   endfunction

   function automatic logic [RES_W-1:0] expected_power(logic [BASE_W-1:0] base,
                                                       logic [EXPO_W-1:0] exponent);
      logic [RES_W-1:0] square;
      logic [RES_W-1:0] acc;
      logic [63:0]      expo_wide;
      square    = RES_W'(64'(base) % 64'(PRIME));
      acc       = ONE;
      expo_wide = 64'(exponent);
      for (int i = 0; i < EXP_BITS && i < 64; i++) begin
         if (expo_wide[i]) acc = mod_mul(acc, square);
         square = mod_mul(square, square);
      end
      return acc;
   endfunction

   assign pending_count = power_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         error_count <= 0;
         power_queue.delete();
      end else begin
         if (req_if.valid && req_if.ready)
            power_queue.push_back(expected_power(req_if.base, req_if.exponent));
         if (rsp_if.valid && rsp_if.ready) begin
            if (power_queue.size() == 0) begin
               $display("%0t: unexpected power item, expected none, actual %0d",
                        $time, rsp_if.power);
               error_count <= error_count + 1;
            end else begin
               logic [RES_W-1:0] want;
               want = power_queue.pop_front();
               if (rsp_if.power !== want) begin
                  $display("%0t: power mismatch, expected %0d, actual %0d",
                           $time, want, rsp_if.power);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule : mexp_checker

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Directed and random requests for modular exponentiation, with bursty idle
// and response stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;
   import mexp_pkg::*;

   localparam int RANDOM_ITEMS = 1830;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   idle_cycles = 0;
   bit   quiet_phase = 1'b0;

   mexp_req_if req_if ();
   mexp_rsp_if rsp_if ();

   modular_exponentiation dut (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if));

   mexp_checker checker_inst (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response stalls in bursts, none once the run is in its last part
   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_if.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= (stall_left == 0);
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(logic [BASE_W-1:0] base, logic [EXPO_W-1:0] exponent);
      req_if.valid    <= 1'b1;
      req_if.base     <= base;
      req_if.exponent <= exponent;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic idle_burst();
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic logic [BASE_W-1:0] pick_base();
      case ($urandom_range(0, 5))
         0: return BASE_W'($urandom_range(0, 3));
         1: return PRIME - BASE_W'($urandom_range(1, 3));
         2: return BASE_W'({$urandom} % 32'(PRIME));
         3: return '1 - BASE_W'($urandom_range(0, 3));
         default: return BASE_W'($urandom);
      endcase
   endfunction

   function automatic logic [EXPO_W-1:0] pick_exponent();
      case ($urandom_range(0, 4))
         0: return EXPO_W'($urandom_range(0, 20));
         1: return '1 - EXPO_W'($urandom_range(0, 3));
         2: return EXPO_W'(1) << $urandom_range(0, 31);
         default: return EXPO_W'($urandom);
      endcase
   endfunction

   initial begin
      int drain;
      req_if.valid    = 1'b0;
      req_if.base     = '0;
      req_if.exponent = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and extreme exponents, extreme bases, bases at and above the prime
      send_item('0, '0);
      send_item('1, '0);
      send_item('0, 32'd1);
      send_item(ONE, '1);
      send_item(PRIME - 30'd1, '1);
      send_item(PRIME - 30'd1, 32'd2);
      send_item(PRIME, 32'd5);
      send_item(PRIME + 30'd1, 32'd7);
      send_item('1, '1);
      send_item('1, 32'h8000_0000);
      send_item(30'd2, 32'd29);
      send_item(30'd3, PRIME - 32'd2);
      send_item(30'h2AAA_AAAA, 32'h5555_5555);
      send_item(30'h1555_5555, 32'hAAAA_AAAA);
      send_item(30'd12345, 32'd1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 300) quiet_phase = 1'b1;
         idle_burst();
         send_item(pick_base(), pick_exponent());
      end
      req_if.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      drain = DRAIN_CYCLES;
      while (drain > 0) begin
         @(posedge clock);
         drain--;
      end
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule : testbench

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation.sv
tb/sv/mexp_checker.sv
tb/sv/testbench.sv
